// ----- design/ps2wm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 wheel-mouse decoder package
// Shared widths, register indexes, beat payload types and the clamp function.
// ----------------------------------------------------------------------------
package ps2wm_pkg;

  localparam int POS_BITS   = 13;
  localparam int LIMIT_BITS = 14;
  localparam int CALC_BITS  = ((POS_BITS > LIMIT_BITS) ? POS_BITS : LIMIT_BITS) + 2;

  localparam logic [POS_BITS-1:0]   RESET_X = POS_BITS'(512);
  localparam logic [POS_BITS-1:0]   RESET_Y = POS_BITS'(384);
  localparam logic [POS_BITS-1:0]   POS_MAX = {POS_BITS{1'b1}};
  localparam logic [LIMIT_BITS-1:0] RESET_WIDTH  = LIMIT_BITS'(1024);
  localparam logic [LIMIT_BITS-1:0] RESET_HEIGHT = LIMIT_BITS'(768);

  localparam logic [7:0] SYNC_BIT      = 8'h08;
  localparam logic [7:0] OVERFLOW_BITS = 8'hC0;
  localparam logic [7:0] BUTTON_MASK   = 8'h07;
  localparam logic [1:0] LAST_BYTE_POS = 2'd3;

  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WHEEL_MODE    = 2'd2;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] screen_width;
    logic [LIMIT_BITS-1:0] screen_height;
    logic                  wheel_mode;
  } cfg_t;

  // A complete packet without overflow, presented for one cycle.
  typedef struct packed {
    logic        valid;
    logic [2:0]  buttons;
    logic [7:0]  dx;
    logic [7:0]  dy;
    logic [7:0]  wheel;
  } pkt_t;

  typedef struct packed {
    logic [POS_BITS-1:0] cursor_x;
    logic [POS_BITS-1:0] cursor_y;
    logic signed [7:0]   delta_x;
    logic signed [7:0]   delta_y;
    logic [2:0]          button_bits;
    logic                moved_flag;
    logic                button_change_flag;
    logic                wheel_flag;
    logic signed [7:0]   wheel_delta;
    logic [31:0]         event_number;
  } event_t;

  // Clamp to zero, below the limit (zero means none) and to the field top.
  function automatic logic [POS_BITS-1:0] clamp_pos(
    input logic signed [CALC_BITS-1:0] v,
    input logic [LIMIT_BITS-1:0]       limit
  );
    logic signed [CALC_BITS-1:0] r;
    logic signed [CALC_BITS-1:0] lim;
    logic signed [CALC_BITS-1:0] top;
    lim = $signed({{(CALC_BITS-LIMIT_BITS){1'b0}}, limit});
    top = $signed({{(CALC_BITS-POS_BITS){1'b0}}, POS_MAX});
    r = v;
    if (r < 0) begin
      r = '0;
    end
    if ((limit != '0) && (r >= lim)) begin
      r = lim - CALC_BITS'(1);
    end
    if (r > top) begin
      r = top;
    end
    return r[POS_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- design/ps2wm_intf.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 wheel-mouse decoder channels
// Byte channel from the mouse port and event channel to the consumer.
// ----------------------------------------------------------------------------
interface ps2wm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ps2wm_event_if;
  import ps2wm_pkg::*;
  logic   valid;
  logic   ready;
  event_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- design/ps2wm_assembler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 wheel-mouse packet assembler
// Registers each byte beat, tracks the byte position and holds the first
// three bytes; flags a complete packet that has no overflow bit set.
// ----------------------------------------------------------------------------
module ps2wm_assembler (
  input  wire logic           clk,
  input  wire logic           rst,
  ps2wm_byte_if.sink          rx,
  input  wire logic           room,
  output ps2wm_pkg::pkt_t     pkt
);
  import ps2wm_pkg::*;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic [1:0] byte_position;
  logic [7:0] held_bytes [3];
  logic       fire;
  logic       sync_ok;

  assign fire     = hold_valid && room;
  assign rx.ready = !hold_valid || room;
  assign sync_ok  = (hold_byte & SYNC_BIT) != 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (rx.ready) begin
      hold_valid <= rx.valid;
    end
    if (rx.ready && rx.valid) begin
      hold_byte <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (fire && ((byte_position != 2'd0) || sync_ok)) begin
      byte_position <= byte_position + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (byte_position != LAST_BYTE_POS) && ((byte_position != 2'd0) || sync_ok)) begin
      held_bytes[byte_position] <= hold_byte;
    end
  end

  always_comb begin
    pkt.valid   = fire && (byte_position == LAST_BYTE_POS) &&
                  ((held_bytes[0] & OVERFLOW_BITS) == 8'h00);
    pkt.buttons = held_bytes[0][2:0] & BUTTON_MASK[2:0];
    pkt.dx      = held_bytes[1];
    pkt.dy      = held_bytes[2];
    pkt.wheel   = hold_byte;
  end

endmodule
`default_nettype wire

// ----- design/ps2wm_cursor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 wheel-mouse cursor and event stage
// Applies a good packet to the clamped cursor, tracks buttons and the event
// count, and holds the event in the output register until it is taken.
// ----------------------------------------------------------------------------
module ps2wm_cursor (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire ps2wm_pkg::cfg_t cfg,
  input  wire ps2wm_pkg::pkt_t pkt,
  output logic            room,
  ps2wm_event_if.source   evt
);
  import ps2wm_pkg::*;

  logic [POS_BITS-1:0]  pos_x;
  logic [POS_BITS-1:0]  pos_y;
  logic [2:0]           last_buttons;
  logic [31:0]          event_count;
  logic                 out_valid;
  event_t               out_evt;
  event_t               evt_next;
  logic [POS_BITS-1:0]  pos_x_next;
  logic [POS_BITS-1:0]  pos_y_next;
  logic signed [CALC_BITS-1:0] sum_x;
  logic signed [CALC_BITS-1:0] sum_y;
  logic [7:0]           wheel;

  assign room        = !out_valid || evt.ready;
  assign evt.valid   = out_valid;
  assign evt.payload = out_evt;

  always_comb begin
    // y grows downward, so the packet's up-positive dy is subtracted.
    sum_x = $signed({{(CALC_BITS-POS_BITS){1'b0}}, pos_x}) +
            $signed({{(CALC_BITS-8){pkt.dx[7]}}, pkt.dx});
    sum_y = $signed({{(CALC_BITS-POS_BITS){1'b0}}, pos_y}) -
            $signed({{(CALC_BITS-8){pkt.dy[7]}}, pkt.dy});
    pos_x_next = clamp_pos(sum_x, cfg.screen_width);
    pos_y_next = clamp_pos(sum_y, cfg.screen_height);
    wheel      = cfg.wheel_mode ? pkt.wheel : 8'h00;

    evt_next.cursor_x           = pos_x_next;
    evt_next.cursor_y           = pos_y_next;
    evt_next.delta_x            = $signed(pkt.dx);
    evt_next.delta_y            = $signed(pkt.dy);
    evt_next.button_bits        = pkt.buttons;
    evt_next.moved_flag         = (pkt.dx != 8'h00) || (pkt.dy != 8'h00);
    evt_next.button_change_flag = pkt.buttons != last_buttons;
    evt_next.wheel_flag         = wheel != 8'h00;
    evt_next.wheel_delta        = $signed(wheel);
    evt_next.event_number       = event_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x        <= RESET_X;
      pos_y        <= RESET_Y;
      last_buttons <= '0;
      event_count  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (pkt.valid) begin
        pos_x        <= pos_x_next;
        pos_y        <= pos_y_next;
        last_buttons <= pkt.buttons;
        event_count  <= event_count + 32'd1;
        out_valid    <= 1'b1;
      end else if (evt.ready) begin
        out_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.valid) begin
      out_evt <= evt_next;
    end
  end

  a_x_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (cfg.screen_width != '0) |->
      ({{(LIMIT_BITS+1){1'b0}}, out_evt.cursor_x} < {{(POS_BITS+1){1'b0}}, cfg.screen_width}))
    else $error("cursor_x at or beyond screen width");

  a_y_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (cfg.screen_height != '0) |->
      ({{(LIMIT_BITS+1){1'b0}}, out_evt.cursor_y} < {{(POS_BITS+1){1'b0}}, cfg.screen_height}))
    else $error("cursor_y at or beyond screen height");

  a_buttons_tracked: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_evt.button_bits == last_buttons))
    else $error("held event buttons differ from tracked buttons");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_evt.event_number + 32'd1 == event_count))
    else $error("event number out of step with event count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    pkt.valid |-> room)
    else $error("packet loaded while the event register is full");

endmodule
`default_nettype wire

// ----- design/ps2_wheel_mouse_packet_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 wheel-mouse packet decoder
// Assembles 4-byte wheel-mouse packets and emits clamped cursor events.
// ----------------------------------------------------------------------------
// Path: the fourth byte beat is taken into the byte register, and its event
// is loaded into the event register once that register has room.
// Throughput: one byte beat per cycle; the byte and event registers stall
// only while the event register is full and not being taken.
// Reset (synchronous): cursor 512/384, buttons and event count cleared,
// packet assembly restarts, limits 1024 by 768, wheel enabled.
module ps2_wheel_mouse_packet_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [ps2wm_pkg::LIMIT_BITS-1:0] cfg_data,
  ps2wm_byte_if.sink       rx,
  ps2wm_event_if.source    evt
);
  import ps2wm_pkg::*;

  cfg_t cfg;
  pkt_t pkt;
  logic room;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= RESET_WIDTH;
      cfg.screen_height <= RESET_HEIGHT;
      cfg.wheel_mode    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data;
        REG_WHEEL_MODE:    cfg.wheel_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ps2wm_assembler u_assembler (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .room (room),
    .pkt  (pkt)
  );

  ps2wm_cursor u_cursor (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .pkt  (pkt),
    .room (room),
    .evt  (evt)
  );

endmodule
`default_nettype wire

// ----- bench/tb_ps2_wheel_mouse_packet_decoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PS/2 wheel-mouse packet decoder testbench
// Sends mouse bytes through the byte channel. A short scripted sequence comes
// first, then phases of random packets and noise, each with its own screen
// limits, wheel mode and idle pattern. A local packet decoder predicts every
// event, and each event beat is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_ps2_wheel_mouse_packet_decoder;
  import ps2wm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SCRIPT_LEN  = 25;
  localparam int N_PHASES    = 8;
  localparam int POS_TOP     = (1 << POS_BITS) - 1;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    event_t     want;
  } script_row_t;

  localparam event_t NO_EVT = '0;

  // Rows with a typed event carry the result that the packet must produce.
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{8'h00, 1'b0, NO_EVT},
    '{8'h09, 1'b0, NO_EVT},
    '{8'h7f, 1'b0, NO_EVT},
    '{8'h80, 1'b0, NO_EVT},
    '{8'h01, 1'b1, '{13'd639, 13'd512, 8'h7f, 8'h80, 3'd1, 1'b1, 1'b1, 1'b1,
                    8'h01, 32'd0}},
    '{8'hc8, 1'b0, NO_EVT},
    '{8'h10, 1'b0, NO_EVT},
    '{8'h10, 1'b0, NO_EVT},
    '{8'h05, 1'b0, NO_EVT},
    '{8'h08, 1'b0, NO_EVT},
    '{8'h00, 1'b0, NO_EVT},
    '{8'h00, 1'b0, NO_EVT},
    '{8'h00, 1'b1, '{13'd639, 13'd512, 8'h00, 8'h00, 3'd0, 1'b0, 1'b1, 1'b0,
                    8'h00, 32'd1}},
    '{8'h0f, 1'b0, NO_EVT},
    '{8'h80, 1'b0, NO_EVT},
    '{8'h7f, 1'b0, NO_EVT},
    '{8'hff, 1'b1, '{13'd511, 13'd385, 8'h80, 8'h7f, 3'd7, 1'b1, 1'b1, 1'b1,
                    8'hff, 32'd2}},
    '{8'h48, 1'b0, NO_EVT},
    '{8'h01, 1'b0, NO_EVT},
    '{8'h01, 1'b0, NO_EVT},
    '{8'h01, 1'b0, NO_EVT},
    '{8'h88, 1'b0, NO_EVT},
    '{8'h01, 1'b0, NO_EVT},
    '{8'h01, 1'b0, NO_EVT},
    '{8'h01, 1'b0, NO_EVT}
  };

  // The first phases pin the limit extremes and push the cursor to its edges.
  localparam int PHASE_W     [N_PHASES] = '{0, 8192, 16383, 1, 640, 0, 0, 0};
  localparam int PHASE_H     [N_PHASES] = '{0, 8192, 16383, 1, 480, 0, 0, 0};
  localparam bit PHASE_WHEEL [N_PHASES] = '{1, 1, 0, 0, 1, 0, 0, 0};
  localparam int PHASE_DX    [N_PHASES] = '{1, 1, -1, -1, -1, 0, 0, 0};
  localparam int PHASE_DY    [N_PHASES] = '{-1, -1, 1, 1, 1, 0, 0, 0};
  localparam int PHASE_BYTES [N_PHASES] = '{380, 120, 100, 80, 120, 110, 110, 110};

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [LIMIT_BITS-1:0] cfg_data;

  ps2wm_byte_if  byte_ch ();
  ps2wm_event_if evt_ch ();

  ps2_wheel_mouse_packet_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (byte_ch),
    .evt       (evt_ch)
  );

  // Scripted expectation travelling with the byte beat.
  logic   beat_typed;
  event_t beat_want;

  int gap_pct;
  int stall_pct;
  int bytes_sent;
  int mismatch_count;
  int cycle_count;

  // Decoder state mirrored by the testbench.
  logic [1:0] asm_pos;
  logic [7:0] asm_bytes [0:2];
  logic [2:0] prev_buttons;
  int         cur_x;
  int         cur_y;
  logic [31:0] evt_count;
  int         lim_w;
  int         lim_h;
  bit         wheel_on;

  event_t pending_events [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("[ps2_wheel_mouse_packet_decoder] ERROR");
        $finish;
      end
    end
  end

  function automatic int clamp_coord(input int v, input int lim);
    int r;
    r = (v < 0) ? 0 : v;
    if (lim != 0 && r >= lim) r = lim - 1;
    if (r > POS_TOP) r = POS_TOP;
    return r;
  endfunction

  task automatic decode_mouse_byte(input logic [7:0] b, output bit fire,
                                   output event_t ev);
    logic [2:0] btn;
    logic signed [7:0] mx;
    logic signed [7:0] my;
    logic signed [7:0] whl;
    fire = 1'b0;
    ev = '0;
    if (asm_pos == 2'd0 && (b & SYNC_BIT) == 8'h00) return;
    if (asm_pos != LAST_BYTE_POS) begin
      asm_bytes[asm_pos] = b;
      asm_pos = asm_pos + 2'd1;
      return;
    end
    asm_pos = 2'd0;
    // Packets with either overflow bit leave the cursor and counters alone.
    if ((asm_bytes[0] & OVERFLOW_BITS) != 8'h00) return;
    btn = 3'(asm_bytes[0] & BUTTON_MASK);
    mx = asm_bytes[1];
    my = asm_bytes[2];
    whl = wheel_on ? b : 8'sh00;
    cur_x = clamp_coord(cur_x + int'(mx), lim_w);
    cur_y = clamp_coord(cur_y - int'(my), lim_h);
    ev.cursor_x           = POS_BITS'(cur_x);
    ev.cursor_y           = POS_BITS'(cur_y);
    ev.delta_x            = mx;
    ev.delta_y            = my;
    ev.button_bits        = btn;
    ev.moved_flag         = (mx != 0) || (my != 0);
    ev.button_change_flag = (btn != prev_buttons);
    ev.wheel_flag         = (whl != 0);
    ev.wheel_delta        = whl;
    ev.event_number       = evt_count;
    evt_count = evt_count + 32'd1;
    prev_buttons = btn;
    fire = 1'b1;
  endtask

  task automatic check_field(input string fld, input logic [31:0] want,
                             input logic [31:0] got, input logic [31:0] num);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("event %0d: %s expected %0h, got %0h", num, fld, want, got);
    end
  endtask

  task automatic check_event(input event_t got);
    event_t want;
    if (pending_events.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("event beat with nothing expected: %p", got);
      return;
    end
    want = pending_events.pop_front();
    check_field("cursor_x", want.cursor_x, got.cursor_x, want.event_number);
    check_field("cursor_y", want.cursor_y, got.cursor_y, want.event_number);
    check_field("delta_x", want.delta_x, got.delta_x, want.event_number);
    check_field("delta_y", want.delta_y, got.delta_y, want.event_number);
    check_field("button_bits", want.button_bits, got.button_bits, want.event_number);
    check_field("moved_flag", want.moved_flag, got.moved_flag, want.event_number);
    check_field("button_change_flag", want.button_change_flag,
                got.button_change_flag, want.event_number);
    check_field("wheel_flag", want.wheel_flag, got.wheel_flag, want.event_number);
    check_field("wheel_delta", want.wheel_delta, got.wheel_delta, want.event_number);
    check_field("event_number", want.event_number, got.event_number,
                want.event_number);
  endtask

  // Both channels are sampled at the edge, before any driven update lands.
  always @(posedge clk) begin : observe
    bit fire;
    event_t ev;
    if (rst) begin
      asm_pos = 2'd0;
      prev_buttons = 3'd0;
      cur_x = int'(RESET_X);
      cur_y = int'(RESET_Y);
      evt_count = 32'd0;
      lim_w = int'(RESET_WIDTH);
      lim_h = int'(RESET_HEIGHT);
      wheel_on = 1'b1;
    end else begin
      if (evt_ch.valid && evt_ch.ready) check_event(evt_ch.payload);
      if (byte_ch.valid && byte_ch.ready) begin
        decode_mouse_byte(byte_ch.rx_byte, fire, ev);
        if (fire) pending_events.push_back(beat_typed ? beat_want : ev);
      end
    end
  end

  // Event consumer with random stall bursts.
  initial begin : consumer
    int hold;
    hold = 0;
    evt_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        evt_ch.ready <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        evt_ch.ready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        hold = $urandom_range(0, 5);
        evt_ch.ready <= 1'b0;
      end else begin
        evt_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input event_t want = '0);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    beat_typed      <= typed;
    beat_want       <= want;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_delta(input int dir);
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return 8'h00;
    if (r < 5) return 8'($urandom_range(0, 255));
    if (dir >= 0) return 8'($urandom_range(96, 127));
    return 8'(-$urandom_range(96, 128));
  endfunction

  // Mostly well-formed packets; the rest are stray bytes and overflow packets.
  task automatic send_packet(input int dir_x, input int dir_y);
    logic [7:0] head;
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      push_byte(8'($urandom_range(0, 255)));
      return;
    end
    head = 8'($urandom_range(0, 255)) | SYNC_BIT;
    if (r < 88) head = head & ~OVERFLOW_BITS;
    push_byte(head);
    push_byte(pick_delta(dir_x));
    push_byte(pick_delta(dir_y));
    push_byte(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
  endtask

  // Dropped packets leave nothing in the queue, so drain also waits out the
  // pipeline after the queue is empty before the block counts as idle.
  task automatic drain();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input int w, input int h, input bit wm);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data  <= LIMIT_BITS'(w);
    @(posedge clk);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data  <= LIMIT_BITS'(h);
    @(posedge clk);
    cfg_index <= REG_WHEEL_MODE;
    cfg_data  <= LIMIT_BITS'(wm);
    @(posedge clk);
    cfg_we   <= 1'b0;
    lim_w    = w & ((1 << LIMIT_BITS) - 1);
    lim_h    = h & ((1 << LIMIT_BITS) - 1);
    wheel_on = wm;
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  initial begin : stimulus
    int w;
    int h;
    bit wm;
    int dir_x;
    int dir_y;
    int stop_at;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_SCREEN_WIDTH;
    cfg_data        <= '0;
    byte_ch.valid   <= 1'b0;
    byte_ch.rx_byte <= 8'h00;
    beat_typed      <= 1'b0;
    beat_want       <= '0;
    gap_pct = 20;
    stall_pct = 20;
    bytes_sent = 0;
    mismatch_count = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < SCRIPT_LEN; i++)
      push_byte(SCRIPT[i].b, SCRIPT[i].typed, SCRIPT[i].want);
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 5) begin
        w = PHASE_W[ph];
        h = PHASE_H[ph];
        wm = PHASE_WHEEL[ph];
        dir_x = PHASE_DX[ph];
        dir_y = PHASE_DY[ph];
      end else begin
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 8192);
        h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 8192);
        wm = $urandom_range(0, 1);
        dir_x = $urandom_range(0, 1) ? 1 : -1;
        dir_y = $urandom_range(0, 1) ? 1 : -1;
      end
      set_config(w, h, wm);
      // The closing phase runs with both sides streaming.
      if (ph == N_PHASES - 1) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = pick_idle_pct();
        stall_pct = pick_idle_pct();
      end
      stop_at = bytes_sent + PHASE_BYTES[ph];
      while (bytes_sent < stop_at) send_packet(dir_x, dir_y);
      drain();
    end

    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("[ps2_wheel_mouse_packet_decoder] OK");
    end else begin
      $display("[ps2_wheel_mouse_packet_decoder] ERROR");
    end
    $finish;
  end

endmodule
